// ----- hdl/spmd_pkg.sv -----
// Shared types, constants and the default-action helper function of the signal dispatch unit.
package spmd_pkg;

  localparam int NUM_SIGNALS = 32;
  localparam int TOKEN_BITS  = 8;
  localparam int SIG_W       = $clog2(NUM_SIGNALS);

  localparam int SIG_NOCATCH_A = 9;
  localparam int SIG_NOCATCH_B = 19;
  localparam int SIG_DFL_IGN_A = 17;
  localparam int SIG_DFL_IGN_B = 18;
  localparam int SIG_DFL_IGN_C = 28;
  localparam int SIG_DFL_STOP_LO = 19;
  localparam int SIG_DFL_STOP_HI = 22;

  localparam logic [TOKEN_BITS-1:0] DISP_DEFAULT = TOKEN_BITS'(0);
  localparam logic [TOKEN_BITS-1:0] DISP_IGNORE  = TOKEN_BITS'(1);

  // bits 9 and 19 can never be blocked
  localparam logic [NUM_SIGNALS-1:0] KEEP_MASK =
    ~((NUM_SIGNALS'(1) << SIG_NOCATCH_A) | (NUM_SIGNALS'(1) << SIG_NOCATCH_B));

  typedef enum logic [2:0] {
    REQ_RAISE    = 3'd0,
    REQ_SET_DISP = 3'd1,
    REQ_BLOCK    = 3'd2,
    REQ_UNBLOCK  = 3'd3,
    REQ_SET_MASK = 3'd4,
    REQ_DELIVER  = 3'd5,
    REQ_READ_PND = 3'd6,
    REQ_INVALID  = 3'd7
  } req_code_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_IGNORE = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_TERM   = 3'd3,
    ACT_USER   = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_SCAN,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_code_t   req_type;
    logic [5:0]  signal_number;
    logic [7:0]  disposition_value;
    logic [31:0] mask_value;
  } req_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] old_value;
    logic        delivered;
    logic [4:0]  delivered_signal;
    act_t        action;
    logic [7:0]  handler_token;
  } res_t;

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [SIG_W-1:0]      addr;
    logic [TOKEN_BITS-1:0] wdata;
  } ram_req_t;

  function automatic act_t default_action(input logic [SIG_W-1:0] s);
    act_t a;
    if (s == SIG_W'(SIG_DFL_IGN_A) || s == SIG_W'(SIG_DFL_IGN_B) ||
        s == SIG_W'(SIG_DFL_IGN_C)) begin
      a = ACT_IGNORE;
    end else if (s >= SIG_W'(SIG_DFL_STOP_LO) && s <= SIG_W'(SIG_DFL_STOP_HI)) begin
      a = ACT_STOP;
    end else begin
      a = ACT_TERM;
    end
    return a;
  endfunction

endpackage

// ----- hdl/spmd_if.sv -----
// Request and result channel interfaces of the signal dispatch unit.
interface spmd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  signal_number;
  logic [7:0]  disposition_value;
  logic [31:0] mask_value;

  modport source (output valid, output req_type, output signal_number,
                  output disposition_value, output mask_value, input ready);
  modport sink   (input valid, input req_type, input signal_number,
                  input disposition_value, input mask_value, output ready);
endinterface

interface spmd_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] old_value;
  logic        delivered;
  logic [4:0]  delivered_signal;
  logic [2:0]  action;
  logic [7:0]  handler_token;

  modport source (output valid, output status, output old_value, output delivered,
                  output delivered_signal, output action, output handler_token,
                  input ready);
  modport sink   (input valid, input status, input old_value, input delivered,
                  input delivered_signal, input action, input handler_token,
                  output ready);
endinterface

// ----- hdl/spmd_disp_ram.sv -----
// Disposition table: one port memory with per-entry valid bits and registered read.
module spmd_disp_ram
  import spmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ram_req_t              req,
  output logic [TOKEN_BITS-1:0] rdata
);

  logic [TOKEN_BITS-1:0]  mem_r [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] valid_r;
  logic [TOKEN_BITS-1:0]  rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.addr] <= req.wdata;
    end
  end

  // an entry never written reads as default
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= valid_r[req.addr] ? mem_r[req.addr] : DISP_DEFAULT;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/spmd_seq.sv -----
// Request sequencer: bitmaps, one-signal-per-step deliver scan, table access.
module spmd_seq
  import spmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_fire,
  input  req_item_t             req_item,
  output logic                  idle,
  output ram_req_t              ram_req,
  input  logic [TOKEN_BITS-1:0] ram_rdata,
  output logic                  res_valid,
  output res_t                  res,
  input  logic                  res_take
);

  state_t                 state_r, state_nxt;
  req_item_t              item_r, item_nxt;
  res_t                   res_r, res_nxt;
  logic [NUM_SIGNALS-1:0] pending_r, pending_nxt;
  logic [NUM_SIGNALS-1:0] blocked_r, blocked_nxt;
  logic [NUM_SIGNALS-1:0] ready_r, ready_nxt;
  logic [SIG_W-1:0]       cnt_r, cnt_nxt;

  logic             sig_ok;
  logic             sig_catch;
  logic [SIG_W-1:0] sig_addr;
  logic             scan_last;
  logic [NUM_SIGNALS-1:0] mval_cut;

  assign sig_ok    = (item_r.signal_number >= 6'd1) &&
                     ({26'd0, item_r.signal_number} < 32'(NUM_SIGNALS));
  assign sig_catch = ({26'd0, item_r.signal_number} != 32'(SIG_NOCATCH_A)) &&
                     ({26'd0, item_r.signal_number} != 32'(SIG_NOCATCH_B));
  assign sig_addr  = item_r.signal_number[SIG_W-1:0];
  assign scan_last = (cnt_r == SIG_W'(NUM_SIGNALS - 1));
  assign mval_cut  = item_r.mask_value[NUM_SIGNALS-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (item_r.req_type == REQ_SET_DISP && sig_ok && sig_catch) begin
          state_nxt = ST_WAIT;
        end else if (item_r.req_type == REQ_DELIVER) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WAIT: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (ready_r[cnt_r]) begin
          state_nxt = ST_CHECK;
        end else if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHECK: begin
        if (ram_rdata != DISP_IGNORE || scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt    = item_r;
    res_nxt     = res_r;
    pending_nxt = pending_r;
    blocked_nxt = blocked_r;
    ready_nxt   = ready_r;
    cnt_nxt     = cnt_r;
    ram_req     = '0;
    case (state_r)
      ST_IDLE: begin
        if (req_fire) item_nxt = req_item;
      end
      ST_EXEC: begin
        res_nxt = '0;
        case (item_r.req_type)
          REQ_RAISE: begin
            if (sig_ok) pending_nxt[sig_addr] = 1'b1;
            else res_nxt.status = 1'b1;
          end
          REQ_SET_DISP: begin
            if (sig_ok && sig_catch) begin
              ram_req.rd_en = 1'b1;
              ram_req.addr  = sig_addr;
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          REQ_BLOCK: begin
            res_nxt.old_value = 32'(blocked_r);
            blocked_nxt       = (blocked_r | mval_cut) & KEEP_MASK;
          end
          REQ_UNBLOCK: begin
            res_nxt.old_value = 32'(blocked_r);
            blocked_nxt       = (blocked_r & ~mval_cut) & KEEP_MASK;
          end
          REQ_SET_MASK: begin
            res_nxt.old_value = 32'(blocked_r);
            blocked_nxt       = mval_cut & KEEP_MASK;
          end
          REQ_DELIVER: begin
            // snapshot of candidates; bit 0 is never visited
            ready_nxt = pending_r & ~blocked_r;
            cnt_nxt   = SIG_W'(1);
          end
          REQ_READ_PND: res_nxt.old_value = 32'(pending_r);
          default:      res_nxt.status = 1'b1;
        endcase
      end
      ST_WAIT: begin
        res_nxt.old_value = 32'(ram_rdata);
        ram_req.wr_en     = 1'b1;
        ram_req.addr      = sig_addr;
        ram_req.wdata     = item_r.disposition_value[TOKEN_BITS-1:0];
      end
      ST_SCAN: begin
        if (ready_r[cnt_r]) begin
          ram_req.rd_en = 1'b1;
          ram_req.addr  = cnt_r;
        end else begin
          cnt_nxt = SIG_W'(cnt_r + 1'b1);
        end
      end
      ST_CHECK: begin
        pending_nxt[cnt_r] = 1'b0;
        if (ram_rdata != DISP_IGNORE) begin
          res_nxt.delivered        = 1'b1;
          res_nxt.delivered_signal = 5'(cnt_r);
          if (ram_rdata == DISP_DEFAULT) begin
            res_nxt.action = default_action(cnt_r);
          end else begin
            res_nxt.action        = ACT_USER;
            res_nxt.handler_token = 8'(ram_rdata);
          end
        end else begin
          cnt_nxt = SIG_W'(cnt_r + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= '0;
      blocked_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      blocked_r <= blocked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    ready_r <= ready_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule

// ----- hdl/signal_pending_mask_dispatch.sv -----
// Top level of the signal pending / mask / dispatch unit.
//
//   channel | dir | interface      | beat
//   in_ch   | in  | spmd_req_if    | req_type, signal_number, disposition_value, mask_value
//   out_ch  | out | spmd_rsp_if    | status, old_value, delivered, delivered_signal, action,
//           |     |                | handler_token
//
// One request at a time. Raise, mask, read-pending and error requests pass through EXEC
// to DONE (result valid); set-disposition passes EXEC, WAIT and DONE (table read, then write).
// Deliver scans signals 1 up to the one it stops at (NUM_SIGNALS-1 if none is dispatched),
// with a table read (CHECK) for each pending unblocked signal visited. The sequencer
// returns to idle and accepts the next request once the result moves to the output
// register.
// Synchronous active-low reset clears the state, the pending and blocked bitmaps, the output
// valid and the table valid bits. A result waiting on a stalled out_ch holds in the output
// register while the next request is accepted and processed.
module signal_pending_mask_dispatch
  import spmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spmd_req_if.sink   in_ch,
  spmd_rsp_if.source out_ch
);

  req_item_t             req_item;
  logic                  req_fire;
  logic                  seq_idle;
  ram_req_t              ram_req;
  logic [TOKEN_BITS-1:0] ram_rdata;
  logic                  res_valid;
  res_t                  res;
  logic                  res_take;
  logic                  out_valid_r;
  res_t                  out_r;

  assign req_item.req_type          = req_code_t'(in_ch.req_type);
  assign req_item.signal_number     = in_ch.signal_number;
  assign req_item.disposition_value = in_ch.disposition_value;
  assign req_item.mask_value        = in_ch.mask_value;

  assign in_ch.ready = seq_idle;
  assign req_fire    = in_ch.valid && seq_idle;

  spmd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_fire  (req_fire),
    .req_item  (req_item),
    .idle      (seq_idle),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  spmd_disp_ram u_disp_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.old_value        = out_r.old_value;
  assign out_ch.delivered        = out_r.delivered;
  assign out_ch.delivered_signal = out_r.delivered_signal;
  assign out_ch.action           = out_r.action;
  assign out_ch.handler_token    = out_r.handler_token;

endmodule

// ----- hdl/spmd_checker.sv -----
// Port-level assertions for the signal dispatch unit, bound to the top level.
module spmd_checker
  import spmd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [31:0] out_old_value,
  input logic        out_delivered,
  input logic [4:0]  out_delivered_signal,
  input logic [2:0]  out_action,
  input logic [7:0]  out_handler_token
);

  // stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_old_value) &&
      $stable(out_status) && $stable(out_action) && $stable(out_handler_token))
    else $error("result beat changed while stalled");

  // one request in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_no_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_delivered |->
      out_action == ACT_NONE && out_delivered_signal == 5'd0 &&
      out_handler_token == 8'd0)
    else $error("dispatch fields set without a delivery");

  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_delivered |->
      out_action != ACT_NONE && out_delivered_signal != 5'd0 && !out_status &&
      out_old_value == 32'd0 &&
      (out_action == ACT_USER || out_handler_token == 8'd0))
    else $error("inconsistent delivery result");

  a_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_old_value == 32'd0 && !out_delivered)
    else $error("error result carries data");

endmodule

bind signal_pending_mask_dispatch spmd_checker u_spmd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_status           (out_ch.status),
  .out_old_value        (out_ch.old_value),
  .out_delivered        (out_ch.delivered),
  .out_delivered_signal (out_ch.delivered_signal),
  .out_action           (out_ch.action),
  .out_handler_token    (out_ch.handler_token)
);

// ----- test/tb.sv -----
// Self-checking testbench for the signal pending / mask / dispatch unit.
`timescale 1ns / 1ps

module tb;
  import spmd_pkg::*;

  localparam int N_RANDOM   = 1300;
  localparam int N_DIRECTED = 25;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYC  = 100;
  localparam int MAX_PRINTS = 60;

  typedef struct {
    req_code_t   op;
    logic [5:0]  sig;
    logic [7:0]  disp;
    logic [31:0] mask;
    bit          lit;
    logic        st;
    logic [31:0] oldv;
  } dir_row_t;

  typedef struct {
    req_item_t req;
    bit        lit;
    res_t      want;
  } stim_t;

  logic clk;
  logic rst_n;

  spmd_req_if req_ch();
  spmd_rsp_if rsp_ch();

  signal_pending_mask_dispatch uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // shadow copy of the unit's state
  logic [NUM_SIGNALS-1:0] pend_bits;
  logic [NUM_SIGNALS-1:0] blk_bits;
  logic [TOKEN_BITS-1:0]  disp_tbl [NUM_SIGNALS];

  stim_t    stim_q[$];
  res_t     outcome_q[$];
  dir_row_t dir_tab [N_DIRECTED];
  int       n_total;
  int       n_in     = 0;
  int       err_cnt  = 0;
  int       idle_cnt = 0;

  function automatic bit sig_ok(logic [5:0] s);
    return s >= 6'd1 && int'(s) < NUM_SIGNALS;
  endfunction

  function automatic act_t dflt_act(int s);
    if (s == SIG_DFL_IGN_A || s == SIG_DFL_IGN_B || s == SIG_DFL_IGN_C) return ACT_IGNORE;
    if (s >= SIG_DFL_STOP_LO && s <= SIG_DFL_STOP_HI) return ACT_STOP;
    return ACT_TERM;
  endfunction

  // Applies one request to the shadow state and returns the result it gives.
  function automatic res_t apply_request(req_item_t r);
    res_t                   o;
    logic [NUM_SIGNALS-1:0] rdy;
    logic [NUM_SIGNALS-1:0] nxt;
    logic [TOKEN_BITS-1:0]  d;
    bit                     hit;
    o   = '0;
    hit = 1'b0;
    case (r.req_type)
      REQ_RAISE: begin
        if (sig_ok(r.signal_number)) pend_bits[r.signal_number[SIG_W-1:0]] = 1'b1;
        else o.status = 1'b1;
      end
      REQ_SET_DISP: begin
        if (!sig_ok(r.signal_number) || r.signal_number == SIG_NOCATCH_A ||
            r.signal_number == SIG_NOCATCH_B) begin
          o.status = 1'b1;
        end else begin
          o.old_value = 32'(disp_tbl[r.signal_number[SIG_W-1:0]]);
          disp_tbl[r.signal_number[SIG_W-1:0]] = r.disposition_value[TOKEN_BITS-1:0];
        end
      end
      REQ_BLOCK, REQ_UNBLOCK, REQ_SET_MASK: begin
        o.old_value = 32'(blk_bits);
        if (r.req_type == REQ_BLOCK) nxt = blk_bits | r.mask_value[NUM_SIGNALS-1:0];
        else if (r.req_type == REQ_UNBLOCK) nxt = blk_bits & ~r.mask_value[NUM_SIGNALS-1:0];
        else nxt = r.mask_value[NUM_SIGNALS-1:0];
        blk_bits = nxt & KEEP_MASK;
      end
      REQ_DELIVER: begin
        rdy = pend_bits & ~blk_bits;
        // ignored signals below the first dispatched one are dropped silently
        for (int s = 1; s < NUM_SIGNALS; s++) begin
          if (!hit && rdy[s]) begin
            pend_bits[s] = 1'b0;
            d = disp_tbl[s];
            if (d != DISP_IGNORE) begin
              hit                = 1'b1;
              o.delivered        = 1'b1;
              o.delivered_signal = 5'(s);
              if (d == DISP_DEFAULT) begin
                o.action = dflt_act(s);
              end else begin
                o.action        = ACT_USER;
                o.handler_token = 8'(d);
              end
            end
          end
        end
      end
      REQ_READ_PND: o.old_value = 32'(pend_bits);
      default: o.status = 1'b1;
    endcase
    return o;
  endfunction

  function automatic req_item_t rand_request();
    req_item_t r;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.req_type = REQ_RAISE;
    else if (pick < 42) r.req_type = REQ_SET_DISP;
    else if (pick < 48) r.req_type = REQ_BLOCK;
    else if (pick < 54) r.req_type = REQ_UNBLOCK;
    else if (pick < 58) r.req_type = REQ_SET_MASK;
    else if (pick < 86) r.req_type = REQ_DELIVER;
    else if (pick < 95) r.req_type = REQ_READ_PND;
    else r.req_type = REQ_INVALID;
    if ($urandom_range(0, 9) == 0) r.signal_number = 6'($urandom);
    else r.signal_number = 6'($urandom_range(1, NUM_SIGNALS - 1));
    case ($urandom_range(0, 3))
      0: r.disposition_value = 8'(DISP_DEFAULT);
      1: r.disposition_value = 8'(DISP_IGNORE);
      default: r.disposition_value = 8'($urandom);
    endcase
    // sparse masks keep most signals deliverable
    case ($urandom_range(0, 7))
      0: r.mask_value = 32'h0;
      1: r.mask_value = 32'hFFFF_FFFF;
      2: r.mask_value = $urandom;
      default: r.mask_value = $urandom & $urandom & $urandom;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string fld, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", fld, got, want));
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    stim_t st;
    rst_n                    = 1'b0;
    req_ch.valid             = 1'b0;
    req_ch.req_type          = 3'd0;
    req_ch.signal_number     = 6'd0;
    req_ch.disposition_value = 8'd0;
    req_ch.mask_value        = 32'd0;
    rsp_ch.ready             = 1'b0;
    pend_bits                = '0;
    blk_bits                 = '0;
    foreach (disp_tbl[i]) disp_tbl[i] = DISP_DEFAULT;

    //          op            sig    disp   mask           lit  st    old
    dir_tab = '{
      '{REQ_READ_PND, 6'd0,  8'h00, 32'h0,         1'b1, 1'b0, 32'h0},
      '{REQ_DELIVER,  6'd0,  8'h00, 32'h0,         1'b1, 1'b0, 32'h0},
      '{REQ_RAISE,    6'd0,  8'h00, 32'h0,         1'b1, 1'b1, 32'h0},
      '{REQ_RAISE,    6'd63, 8'h00, 32'h0,         1'b1, 1'b1, 32'h0},
      '{REQ_RAISE,    6'd32, 8'h00, 32'h0,         1'b1, 1'b1, 32'h0},
      '{REQ_SET_DISP, 6'd9,  8'h55, 32'h0,         1'b1, 1'b1, 32'h0},
      '{REQ_SET_DISP, 6'd19, 8'hAA, 32'h0,         1'b1, 1'b1, 32'h0},
      '{REQ_SET_DISP, 6'd0,  8'h12, 32'h0,         1'b1, 1'b1, 32'h0},
      '{REQ_INVALID,  6'd31, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0},
      '{REQ_SET_MASK, 6'd0,  8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{REQ_BLOCK,    6'd0,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_UNBLOCK,  6'd0,  8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{REQ_RAISE,    6'd1,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_RAISE,    6'd31, 8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_SET_DISP, 6'd31, 8'hFF, 32'h0,         1'b1, 1'b0, 32'h0},
      '{REQ_SET_DISP, 6'd1,  8'h01, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_RAISE,    6'd17, 8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_RAISE,    6'd20, 8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_READ_PND, 6'd0,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_DELIVER,  6'd0,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_DELIVER,  6'd0,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_DELIVER,  6'd0,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_RAISE,    6'd9,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0},
      '{REQ_BLOCK,    6'd0,  8'h00, 32'h0008_0200, 1'b0, 1'b0, 32'h0},
      '{REQ_DELIVER,  6'd0,  8'h00, 32'h0,         1'b0, 1'b0, 32'h0}
    };
    foreach (dir_tab[i]) begin
      st.req  = '{dir_tab[i].op, dir_tab[i].sig, dir_tab[i].disp, dir_tab[i].mask};
      st.lit  = dir_tab[i].lit;
      st.want = '{dir_tab[i].st, dir_tab[i].oldv, 1'b0, 5'd0, ACT_NONE, 8'd0};
      stim_q.push_back(st);
    end
    repeat (N_RANDOM) begin
      st.req  = rand_request();
      st.lit  = 1'b0;
      st.want = '0;
      stim_q.push_back(st);
    end
    n_total = stim_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (n_in < n_total || outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // request sender: bursts of random length with random gaps
  stim_t cur;
  res_t  pred;
  int    burst_left;
  int    gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        pred = apply_request(cur.req);
        outcome_q.push_back(cur.lit ? cur.want : pred);
        n_in <= n_in + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0 || stim_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_ch.valid <= 1'b0;
        end else begin
          cur = stim_q.pop_front();
          req_ch.valid             <= 1'b1;
          req_ch.req_type          <= cur.req.req_type;
          req_ch.signal_number     <= cur.req.signal_number;
          req_ch.disposition_value <= cur.req.disposition_value;
          req_ch.mask_value        <= cur.req.mask_value;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // result receiver: rotating stall pattern plus two long hold-offs
  logic [15:0] rx_pat;
  int          rx_ph;
  int          hold_left;
  int          hold_idx;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      rx_pat    = 16'hFFFF;
      rx_ph     = 0;
      hold_left = 0;
      hold_idx  = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (hold_idx < 2 && n_in >= ((hold_idx == 0) ? 300 : 900)) begin
      // long hold-off: the unit backs up and stops taking requests
      hold_left = (hold_idx == 0) ? 400 : 150;
      hold_idx++;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= rx_pat[rx_ph];
      rx_ph++;
      if (rx_ph == 16) begin
        rx_ph = 0;
        case ($urandom_range(0, 3))
          0: rx_pat = 16'hFFFF;
          1: rx_pat = 16'($urandom) | 16'($urandom);
          default: rx_pat = 16'($urandom);
        endcase
      end
    end
  end

  res_t want_r;

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want_r = outcome_q.pop_front();
        check_field("status", 32'(rsp_ch.status), 32'(want_r.status));
        check_field("old_value", rsp_ch.old_value, want_r.old_value);
        check_field("delivered", 32'(rsp_ch.delivered), 32'(want_r.delivered));
        check_field("delivered_signal", 32'(rsp_ch.delivered_signal),
                    32'(want_r.delivered_signal));
        check_field("action", 32'(rsp_ch.action), 32'(want_r.action));
        check_field("handler_token", 32'(rsp_ch.handler_token), 32'(want_r.handler_token));
      end
    end
  end

  // watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
